### design/rtv_pkg.sv
// ----------------------------------------------------------------------------
// rtv_pkg: shared types and constants of the rigid transform block
// Configuration register map, reset values, the configuration bundle and the
// status codes that travel between the modules of the block.
// ----------------------------------------------------------------------------
package rtv_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 48;
    localparam int unsigned ROW_W      = 48;
    localparam int unsigned ENTRY_W    = 16;
    localparam int unsigned OFFSET_W   = 32;
    localparam int unsigned TOL_W      = 29;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW_ZERO    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW_ONE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW_TWO     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_FWD      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_RGT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_DWN      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ORTHO_TOLERANCE = 3'd6;

    // Reset values: the identity rotation in Q1.14, zero offsets.
    localparam logic [ROW_W-1:0]    RST_ROT_ROW_ZERO    = 48'h0000_0000_4000;
    localparam logic [ROW_W-1:0]    RST_ROT_ROW_ONE     = 48'h0000_4000_0000;
    localparam logic [ROW_W-1:0]    RST_ROT_ROW_TWO     = 48'h4000_0000_0000;
    localparam logic [OFFSET_W-1:0] RST_OFFSET          = 32'h0000_0000;
    localparam logic [TOL_W-1:0]    RST_ORTHO_TOLERANCE = 29'd65536;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_UNIT  = 2'd1,
        ST_NOT_ORTHO = 2'd2,
        ST_NOT_RIGHT = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0][ROW_W-1:0]    rot;
        logic [2:0][OFFSET_W-1:0] offs;
        logic [TOL_W-1:0]         tol;
    } t_cfg;

    // One signed rotation entry; column 0 sits in the low bits of a row.
    function automatic logic signed [ENTRY_W-1:0] rot_entry(
        input logic [2:0][ROW_W-1:0] rot,
        input logic [1:0]            r,
        input logic [1:0]            c
    );
        rot_entry = rot[r][{c, 4'b0000} +: ENTRY_W];
    endfunction

endpackage

### design/rtv_cfg_regs.sv
// ----------------------------------------------------------------------------
// rtv_cfg_regs: configuration register file
// Holds the rotation rows, the body-frame offsets and the check tolerance.
// Writes to an index outside the register map are dropped.
// ----------------------------------------------------------------------------
module rtv_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rtv_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rtv_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output rtv_pkg::t_cfg                      o_cfg
);

    rtv_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot[0]  <= rtv_pkg::RST_ROT_ROW_ZERO;
            r_cfg.rot[1]  <= rtv_pkg::RST_ROT_ROW_ONE;
            r_cfg.rot[2]  <= rtv_pkg::RST_ROT_ROW_TWO;
            r_cfg.offs[0] <= rtv_pkg::RST_OFFSET;
            r_cfg.offs[1] <= rtv_pkg::RST_OFFSET;
            r_cfg.offs[2] <= rtv_pkg::RST_OFFSET;
            r_cfg.tol     <= rtv_pkg::RST_ORTHO_TOLERANCE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rtv_pkg::REG_ROT_ROW_ZERO: begin
                    r_cfg.rot[0] <= i_cfg_data[rtv_pkg::ROW_W-1:0];
                end
                rtv_pkg::REG_ROT_ROW_ONE: begin
                    r_cfg.rot[1] <= i_cfg_data[rtv_pkg::ROW_W-1:0];
                end
                rtv_pkg::REG_ROT_ROW_TWO: begin
                    r_cfg.rot[2] <= i_cfg_data[rtv_pkg::ROW_W-1:0];
                end
                rtv_pkg::REG_OFFSET_FWD: begin
                    r_cfg.offs[0] <= i_cfg_data[rtv_pkg::OFFSET_W-1:0];
                end
                rtv_pkg::REG_OFFSET_RGT: begin
                    r_cfg.offs[1] <= i_cfg_data[rtv_pkg::OFFSET_W-1:0];
                end
                rtv_pkg::REG_OFFSET_DWN: begin
                    r_cfg.offs[2] <= i_cfg_data[rtv_pkg::OFFSET_W-1:0];
                end
                rtv_pkg::REG_ORTHO_TOLERANCE: begin
                    r_cfg.tol <= i_cfg_data[rtv_pkg::TOL_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/rtv_check.sv
// ----------------------------------------------------------------------------
// rtv_check: rotation check pipeline
// Four register stages compute the row dot products and the determinant of
// the configured rotation and rank the first failing check into a status.
// ----------------------------------------------------------------------------
module rtv_check #(
    parameter int ROT_FRAC_BITS = 14
) (
    input  logic             i_clk,
    input  rtv_pkg::t_cfg    i_cfg,
    output rtv_pkg::t_status o_status
);

    localparam int EW      = rtv_pkg::ENTRY_W;
    localparam int TW      = rtv_pkg::TOL_W;
    localparam int PROD_W  = 2 * EW;
    localparam int DOT_W   = PROD_W + 2;
    localparam int DIFF_W  = ((2 * ROT_FRAC_BITS + 2 > DOT_W) ?
                              2 * ROT_FRAC_BITS + 2 : DOT_W) + 1;
    localparam int MINOR_W = PROD_W + 1;
    localparam int DPROD_W = EW + MINOR_W;
    localparam int DET_W   = ((3 * ROT_FRAC_BITS + 2 > DPROD_W + 2) ?
                              3 * ROT_FRAC_BITS + 2 : DPROD_W + 2) + 1;

    localparam logic signed [DIFF_W-1:0] ONE2 =
        {{(DIFF_W-1){1'b0}}, 1'b1} << (2 * ROT_FRAC_BITS);
    localparam logic signed [DET_W-1:0]  ONE3 =
        {{(DET_W-1){1'b0}}, 1'b1} << (3 * ROT_FRAC_BITS);

    // Row pairs in check order; a pair of equal rows is a unit-length check.
    localparam int PAIR_A [6] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_B [6] = '{0, 1, 2, 1, 2, 2};
    // Columns of the 2x2 minors of rows one and two, one per column of row 0.
    localparam int MIN_A  [3] = '{1, 0, 0};
    localparam int MIN_B  [3] = '{2, 2, 1};

    logic signed [EW-1:0]      w_e      [3][3];
    logic signed [PROD_W-1:0]  r_dp     [6][3];
    logic signed [PROD_W-1:0]  r_mp     [3][2];
    logic signed [DOT_W-1:0]   r_dot    [6];
    logic signed [MINOR_W-1:0] r_minor  [3];
    logic signed [DIFF_W-1:0]  w_dev    [6];
    logic signed [DIFF_W-1:0]  w_tol;
    logic        [5:0]         w_fail;
    logic        [5:0]         r_fail3;
    logic        [5:0]         r_fail4;
    logic signed [DPROD_W-1:0] r_dprod  [3];
    logic signed [DET_W-1:0]   r_det;
    logic signed [DET_W-1:0]   w_tol_det;
    logic                      w_det_fail;

    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            assign w_e[r][c] = rtv_pkg::rot_entry(i_cfg.rot, 2'(r), 2'(c));
        end
    end

    // The user must keep the configuration fixed while items are in flight;
    // the block does not enforce this. This pipeline runs free and settles
    // before the first item after a write reaches the output stage.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 6; i++) begin
            for (int c = 0; c < 3; c++) begin
                r_dp[i][c] <= w_e[PAIR_A[i]][c] * w_e[PAIR_B[i]][c];
            end
        end
        for (int k = 0; k < 3; k++) begin
            r_mp[k][0] <= w_e[1][MIN_A[k]] * w_e[2][MIN_B[k]];
            r_mp[k][1] <= w_e[1][MIN_B[k]] * w_e[2][MIN_A[k]];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 6; i++) begin
            r_dot[i] <= DOT_W'(r_dp[i][0]) + DOT_W'(r_dp[i][1]) + DOT_W'(r_dp[i][2]);
        end
        for (int k = 0; k < 3; k++) begin
            r_minor[k] <= MINOR_W'(r_mp[k][0]) - MINOR_W'(r_mp[k][1]);
        end
    end

    assign w_tol = $signed({{(DIFF_W-TW){1'b0}}, i_cfg.tol});

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w_dev[i]  = DIFF_W'(r_dot[i]) - ((PAIR_A[i] == PAIR_B[i]) ? ONE2 : '0);
            w_fail[i] = (w_dev[i] > w_tol) || (w_dev[i] < -w_tol);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fail3 <= w_fail;
        for (int k = 0; k < 3; k++) begin
            r_dprod[k] <= w_e[0][k] * r_minor[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_fail4 <= r_fail3;
        r_det   <= DET_W'(r_dprod[0]) - DET_W'(r_dprod[1]) + DET_W'(r_dprod[2]) - ONE3;
    end

    assign w_tol_det = $signed({{(DET_W-TW-ROT_FRAC_BITS){1'b0}}, i_cfg.tol,
                                {ROT_FRAC_BITS{1'b0}}});
    assign w_det_fail = (r_det > w_tol_det) || (r_det < -w_tol_det);

    always_comb begin
        priority if (r_fail4[0]) begin
            o_status = rtv_pkg::ST_NOT_UNIT;
        end else if (r_fail4[1] || r_fail4[2]) begin
            o_status = rtv_pkg::ST_NOT_ORTHO;
        end else if (r_fail4[3]) begin
            o_status = rtv_pkg::ST_NOT_UNIT;
        end else if (r_fail4[4]) begin
            o_status = rtv_pkg::ST_NOT_ORTHO;
        end else if (r_fail4[5]) begin
            o_status = rtv_pkg::ST_NOT_UNIT;
        end else if (w_det_fail) begin
            o_status = rtv_pkg::ST_NOT_RIGHT;
        end else begin
            o_status = rtv_pkg::ST_OK;
        end
    end

endmodule

### design/rtv_xform.sv
// ----------------------------------------------------------------------------
// rtv_xform: point transform pipeline
// Four stages: products, partial sums with offset and rounding bias, final
// sum with the fixed-point shift, and saturation. Valid bits travel with the
// data and each stage moves when the one after it has room.
// ----------------------------------------------------------------------------
module rtv_xform #(
    parameter int COORD_WIDTH   = 32,
    parameter int ROT_FRAC_BITS = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rtv_pkg::t_cfg                 i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_cam [3],
    output logic                          o_valid,
    input  logic                          i_adv,
    output logic signed [COORD_WIDTH-1:0] o_body [3],
    output logic        [2:0]             o_sat
);

    localparam int EW     = rtv_pkg::ENTRY_W;
    localparam int P_W    = EW + COORD_WIDTH;
    localparam int OFF_W  = (COORD_WIDTH < rtv_pkg::OFFSET_W) ?
                            COORD_WIDTH : rtv_pkg::OFFSET_W;
    localparam int SUM_W  = COORD_WIDTH + ((ROT_FRAC_BITS + 2 > 19) ?
                                           ROT_FRAC_BITS + 2 : 19);
    localparam int Q_W    = SUM_W - ROT_FRAC_BITS;
    localparam logic signed [SUM_W-1:0] HALF =
        {{(SUM_W-1){1'b0}}, 1'b1} << (ROT_FRAC_BITS - 1);

    logic [3:0]                   r_vld;
    logic [3:0]                   w_en;
    logic signed [EW-1:0]         w_e    [3][3];
    logic signed [SUM_W-1:0]      w_off  [3];
    logic signed [SUM_W-1:0]      w_sum  [3];
    logic signed [P_W-1:0]        r1_p   [3][3];
    logic signed [SUM_W-1:0]      r2_a   [3];
    logic signed [SUM_W-1:0]      r2_b   [3];
    logic signed [Q_W-1:0]        r3_q   [3];
    logic signed [COORD_WIDTH-1:0] r4_c  [3];
    logic [2:0]                   r4_sat;

    assign w_en[3] = !r_vld[3] || i_adv;
    assign w_en[2] = !r_vld[2] || w_en[3];
    assign w_en[1] = !r_vld[1] || w_en[2];
    assign w_en[0] = !r_vld[0] || w_en[1];
    assign o_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_valid;
            if (w_en[1]) r_vld[1] <= r_vld[0];
            if (w_en[2]) r_vld[2] <= r_vld[1];
            if (w_en[3]) r_vld[3] <= r_vld[2];
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            assign w_e[r][c] = rtv_pkg::rot_entry(i_cfg.rot, 2'(r), 2'(c));
        end
        // Offset is sign-extended from its coordinate width and aligned to
        // the product binary point.
        assign w_off[r] = $signed({{(SUM_W-OFF_W-ROT_FRAC_BITS){i_cfg.offs[r][OFF_W-1]}},
                                   i_cfg.offs[r][OFF_W-1:0], {ROT_FRAC_BITS{1'b0}}});
        assign w_sum[r] = r2_a[r] + r2_b[r];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r1_p[r][c] <= w_e[r][c] * i_cam[c];
                end
            end
        end
        if (w_en[1]) begin
            for (int r = 0; r < 3; r++) begin
                r2_a[r] <= SUM_W'(r1_p[r][0]) + SUM_W'(r1_p[r][1]);
                r2_b[r] <= SUM_W'(r1_p[r][2]) + w_off[r] + HALF;
            end
        end
        if (w_en[2]) begin
            // Dropping the fraction bits of the biased sum rounds to nearest
            // with ties toward plus infinity.
            for (int r = 0; r < 3; r++) begin
                r3_q[r] <= w_sum[r][SUM_W-1:ROT_FRAC_BITS];
            end
        end
        if (w_en[3]) begin
            for (int r = 0; r < 3; r++) begin
                if (r3_q[r][Q_W-1:COORD_WIDTH-1] == '0
                    || r3_q[r][Q_W-1:COORD_WIDTH-1] == '1) begin
                    r4_c[r]   <= r3_q[r][COORD_WIDTH-1:0];
                    r4_sat[r] <= 1'b0;
                end else begin
                    r4_c[r]   <= {r3_q[r][Q_W-1], {(COORD_WIDTH-1){!r3_q[r][Q_W-1]}}};
                    r4_sat[r] <= 1'b1;
                end
            end
        end
    end

    assign o_valid = r_vld[3];
    assign o_body  = r4_c;
    assign o_sat   = r4_sat;

endmodule

### design/rigid_transform_validated.sv
// ----------------------------------------------------------------------------
// rigid_transform_validated: camera-to-body rigid transform with rotation check
// Rotates a camera-frame point by a configured 3x3 matrix, adds an offset and
// reports a status from a check of the matrix that runs beside the data.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_ready) carries a camera-frame point
// (right, down, forward). The output channel (o_out_valid / i_out_ready)
// carries the body-frame point (forward, right, down), a status and a
// saturation flag. Each input transfer gives exactly one output transfer.
// One item can enter every cycle while the output is not stalled, so
// throughput is one point per clock. The path is the pipelined multiply-add
// tree: products, two adder levels, saturation and the output register.
// The rotation check runs through its own four stages from the configuration
// registers and does not stall with the data.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while no
// point is in flight. Reset restores the identity rotation, zero offsets and
// the default tolerance, and empties the pipeline.
// When the receiver stalls, each stage holds until the next one has room;
// empty stages still take new points, so input stalls only once all five
// stages are full.
// ----------------------------------------------------------------------------
module rigid_transform_validated #(
    parameter int COORD_WIDTH   = 32,
    parameter int ROT_FRAC_BITS = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rtv_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rtv_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [COORD_WIDTH-1:0]       i_cam_right,
    input  logic signed [COORD_WIDTH-1:0]       i_cam_down,
    input  logic signed [COORD_WIDTH-1:0]       i_cam_forward,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [COORD_WIDTH-1:0]       o_body_fwd,
    output logic signed [COORD_WIDTH-1:0]       o_body_rgt,
    output logic signed [COORD_WIDTH-1:0]       o_body_dwn,
    output logic [1:0]                          o_status,
    output logic                                o_saturated
);

    rtv_pkg::t_cfg                 w_cfg;
    rtv_pkg::t_status              w_status;
    logic signed [COORD_WIDTH-1:0] w_cam  [3];
    logic signed [COORD_WIDTH-1:0] w_body [3];
    logic [2:0]                    w_sat;
    logic                          w_xf_valid;
    logic                          w_adv;
    logic                          r_out_vld;
    logic signed [COORD_WIDTH-1:0] r_body [3];
    rtv_pkg::t_status              r_status;
    logic                          r_sat;

    rtv_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    rtv_check #(
        .ROT_FRAC_BITS (ROT_FRAC_BITS)
    ) u_check (
        .i_clk    (i_clk),
        .i_cfg    (w_cfg),
        .o_status (w_status)
    );

    assign w_cam[0] = i_cam_right;
    assign w_cam[1] = i_cam_down;
    assign w_cam[2] = i_cam_forward;

    rtv_xform #(
        .COORD_WIDTH   (COORD_WIDTH),
        .ROT_FRAC_BITS (ROT_FRAC_BITS)
    ) u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_cam   (w_cam),
        .o_valid (w_xf_valid),
        .i_adv   (w_adv),
        .o_body  (w_body),
        .o_sat   (w_sat)
    );

    assign w_adv = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_xf_valid;
        end
    end

    // A failed rotation check forces the coordinates and the flag to zero.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_status <= w_status;
            if (w_status == rtv_pkg::ST_OK) begin
                r_body <= w_body;
                r_sat  <= |w_sat;
            end else begin
                r_body <= '{default: '0};
                r_sat  <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_body_fwd  = r_body[0];
    assign o_body_rgt  = r_body[1];
    assign o_body_dwn  = r_body[2];
    assign o_status    = r_status;
    assign o_saturated = r_sat;

endmodule

### design/rtv_checker.sv
// ----------------------------------------------------------------------------
// rtv_checker: port-level checks of the rigid transform block
// Watches the top-level ports for result consistency, stall behavior and the
// handshake of the output channel.
// ----------------------------------------------------------------------------
module rtv_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [COORD_WIDTH-1:0] o_body_fwd,
    input logic signed [COORD_WIDTH-1:0] o_body_rgt,
    input logic signed [COORD_WIDTH-1:0] o_body_dwn,
    input logic [1:0]                    o_status,
    input logic                          o_saturated
);

    localparam logic [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // An error result carries no coordinates and no clip flag.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != rtv_pkg::ST_OK |->
            o_body_fwd == '0 && o_body_rgt == '0 && o_body_dwn == '0 && !o_saturated)
        else $error("error result with nonzero payload");

    // A clipped result shows at least one coordinate at a range limit.
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            o_body_fwd == CMAX || o_body_fwd == CMIN ||
            o_body_rgt == CMAX || o_body_rgt == CMIN ||
            o_body_dwn == CMAX || o_body_dwn == CMIN)
        else $error("saturated flag without a clipped coordinate");

    // With the output register empty, every stage can move, so input is open.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked while output is empty");

    // Nothing comes out in the first cycle after reset is released.
    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_body_fwd) && $stable(o_body_rgt)
            && $stable(o_body_dwn) && $stable(o_status) && $stable(o_saturated))
        else $error("stalled output changed");

endmodule

bind rigid_transform_validated rtv_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_rtv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_body_fwd  (o_body_fwd),
    .o_body_rgt  (o_body_rgt),
    .o_body_dwn  (o_body_dwn),
    .o_status    (o_status),
    .o_saturated (o_saturated)
);

### tb/tb_rigid_transform_validated.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rigid_transform_validated: self-checking bench of the rigid transform
// Loads a series of rotation, offset and tolerance settings while the block is
// idle, streams camera points through it in random bursts against a stalling
// receiver, and checks every body point, status and saturation flag against a
// predictor that keeps its own copy of the registers.
// ----------------------------------------------------------------------------
module tb_rigid_transform_validated;

    localparam int     CW   = 32;
    localparam int     FRAC = 14;
    localparam int     UNIT = 1 << FRAC;
    localparam int     C45  = 11585;
    localparam logic [rtv_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam longint ONE_Q2    = longint'(1) << (2 * FRAC);
    localparam longint ONE_Q3    = longint'(1) << (3 * FRAC);
    localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam logic signed [CW-1:0] CAM_MAX = CW'(COORD_MAX);
    localparam logic signed [CW-1:0] CAM_MIN = CW'(COORD_MIN);

    typedef struct {
        logic signed [CW-1:0] right;
        logic signed [CW-1:0] down;
        logic signed [CW-1:0] forward;
    } t_cam_point;

    typedef struct {
        logic signed [CW-1:0] fwd;
        logic signed [CW-1:0] rgt;
        logic signed [CW-1:0] dwn;
        rtv_pkg::t_status     status;
        logic                 saturated;
    } t_body_point;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE,
        RX_CHOKED
    } t_rx_pattern;

    class body_point_scoreboard;
        rtv_pkg::t_cfg cfg;
        t_body_point   pending_body_points[$];
        int            errors;
        int            checked;
        int            saturated_count;
        int            status_count[4];

        function new();
            cfg.rot[0]  = rtv_pkg::RST_ROT_ROW_ZERO;
            cfg.rot[1]  = rtv_pkg::RST_ROT_ROW_ONE;
            cfg.rot[2]  = rtv_pkg::RST_ROT_ROW_TWO;
            cfg.offs[0] = rtv_pkg::RST_OFFSET;
            cfg.offs[1] = rtv_pkg::RST_OFFSET;
            cfg.offs[2] = rtv_pkg::RST_OFFSET;
            cfg.tol     = rtv_pkg::RST_ORTHO_TOLERANCE;
            errors          = 0;
            checked         = 0;
            saturated_count = 0;
            foreach (status_count[i]) status_count[i] = 0;
        endfunction

        function void write_reg(logic [rtv_pkg::CFG_IDX_W-1:0]  idx,
                                logic [rtv_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                rtv_pkg::REG_ROT_ROW_ZERO:    cfg.rot[0]  = data[rtv_pkg::ROW_W-1:0];
                rtv_pkg::REG_ROT_ROW_ONE:     cfg.rot[1]  = data[rtv_pkg::ROW_W-1:0];
                rtv_pkg::REG_ROT_ROW_TWO:     cfg.rot[2]  = data[rtv_pkg::ROW_W-1:0];
                rtv_pkg::REG_OFFSET_FWD:      cfg.offs[0] = data[rtv_pkg::OFFSET_W-1:0];
                rtv_pkg::REG_OFFSET_RGT:      cfg.offs[1] = data[rtv_pkg::OFFSET_W-1:0];
                rtv_pkg::REG_OFFSET_DWN:      cfg.offs[2] = data[rtv_pkg::OFFSET_W-1:0];
                rtv_pkg::REG_ORTHO_TOLERANCE: cfg.tol     = data[rtv_pkg::TOL_W-1:0];
                default: ;
            endcase
        endfunction

        function longint entry(int r, int c);
            logic signed [rtv_pkg::ENTRY_W-1:0] e;
            e = cfg.rot[r][rtv_pkg::ENTRY_W*c +: rtv_pkg::ENTRY_W];
            return e;
        endfunction

        function longint row_dot(int a, int b);
            longint s;
            s = 0;
            for (int c = 0; c < 3; c++) s += entry(a, c) * entry(b, c);
            return s;
        endfunction

        function longint magnitude(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // Checks run row by row: unit length first, then against later rows.
        function rtv_pkg::t_status rotation_status();
            longint tol;
            longint det;
            tol = longint'(cfg.tol);
            for (int r = 0; r < 3; r++) begin
                if (magnitude(row_dot(r, r) - ONE_Q2) > tol) return rtv_pkg::ST_NOT_UNIT;
                for (int o = r + 1; o < 3; o++)
                    if (magnitude(row_dot(r, o)) > tol) return rtv_pkg::ST_NOT_ORTHO;
            end
            det = entry(0, 0) * (entry(1, 1) * entry(2, 2) - entry(1, 2) * entry(2, 1))
                - entry(0, 1) * (entry(1, 0) * entry(2, 2) - entry(1, 2) * entry(2, 0))
                + entry(0, 2) * (entry(1, 0) * entry(2, 1) - entry(1, 1) * entry(2, 0));
            if (magnitude(det - ONE_Q3) > (tol <<< FRAC)) return rtv_pkg::ST_NOT_RIGHT;
            return rtv_pkg::ST_OK;
        endfunction

        function t_body_point predict_body_point(t_cam_point p);
            t_body_point res;
            longint      cam[3];
            longint      acc;
            logic signed [rtv_pkg::OFFSET_W-1:0] off;
            res.fwd       = '0;
            res.rgt       = '0;
            res.dwn       = '0;
            res.saturated = 1'b0;
            res.status    = rotation_status();
            if (res.status != rtv_pkg::ST_OK) return res;
            cam[0] = p.right;
            cam[1] = p.down;
            cam[2] = p.forward;
            for (int r = 0; r < 3; r++) begin
                // Offset and the half LSB join the exact sum; one floor shift
                // then rounds to nearest with ties going up.
                off = cfg.offs[r];
                acc = (longint'(off) <<< FRAC) + (longint'(1) <<< (FRAC - 1));
                for (int c = 0; c < 3; c++) acc += entry(r, c) * cam[c];
                acc = acc >>> FRAC;
                if (acc > COORD_MAX) begin
                    acc = COORD_MAX;
                    res.saturated = 1'b1;
                end else if (acc < COORD_MIN) begin
                    acc = COORD_MIN;
                    res.saturated = 1'b1;
                end
                case (r)
                    0:       res.fwd = acc[CW-1:0];
                    1:       res.rgt = acc[CW-1:0];
                    default: res.dwn = acc[CW-1:0];
                endcase
            end
            return res;
        endfunction

        function void note_camera_point(t_cam_point p);
            pending_body_points.push_back(predict_body_point(p));
        endfunction

        function void check_field(string name, longint want, longint got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_body_point(t_body_point got);
            t_body_point want;
            if (pending_body_points.size() == 0) begin
                errors++;
                $display("%0t: unexpected body point, expected none, actual %0d %0d %0d %s %0d",
                         $time, got.fwd, got.rgt, got.dwn, "status", got.status);
                return;
            end
            want = pending_body_points.pop_front();
            checked++;
            status_count[want.status]++;
            if (want.saturated) saturated_count++;
            check_field("body_fwd", want.fwd, got.fwd);
            check_field("body_rgt", want.rgt, got.rgt);
            check_field("body_dwn", want.dwn, got.dwn);
            check_field("status", longint'(want.status), longint'(got.status));
            check_field("saturated", want.saturated, got.saturated);
        endfunction
    endclass

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    logic [rtv_pkg::CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [rtv_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                           i_in_valid    = 1'b0;
    logic                           o_in_ready;
    logic signed [CW-1:0]           i_cam_right   = '0;
    logic signed [CW-1:0]           i_cam_down    = '0;
    logic signed [CW-1:0]           i_cam_forward = '0;
    logic                           o_out_valid;
    logic                           i_out_ready   = 1'b0;
    logic signed [CW-1:0]           o_body_fwd;
    logic signed [CW-1:0]           o_body_rgt;
    logic signed [CW-1:0]           o_body_dwn;
    logic [1:0]                     o_status;
    logic                           o_saturated;

    body_point_scoreboard sb = new();
    int                   burst_left    = 0;
    int                   setting_count = 0;
    t_rx_pattern          rx_pattern    = RX_OPEN;
    int unsigned          rx_tick       = 0;

    rigid_transform_validated #(
        .COORD_WIDTH   (CW),
        .ROT_FRAC_BITS (FRAC)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cam_right   (i_cam_right),
        .i_cam_down    (i_cam_down),
        .i_cam_forward (i_cam_forward),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_body_fwd    (o_body_fwd),
        .o_body_rgt    (o_body_rgt),
        .o_body_dwn    (o_body_dwn),
        .o_status      (o_status),
        .o_saturated   (o_saturated)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #(5_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    // Output side: check each transfer, then pick the next ready value from a
    // randomly chosen receive pattern.
    always @(posedge i_clk) begin
        t_body_point got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.fwd       = o_body_fwd;
            got.rgt       = o_body_rgt;
            got.dwn       = o_body_dwn;
            got.status    = rtv_pkg::t_status'(o_status);
            got.saturated = o_saturated;
            sb.check_body_point(got);
        end
        rx_tick <= rx_tick + 1;
        if (rx_tick % 97 == 0) rx_pattern <= t_rx_pattern'($urandom_range(0, 3));
        case (rx_pattern)
            RX_OPEN:   i_out_ready <= 1'b1;
            RX_RANDOM: i_out_ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: i_out_ready <= (rx_tick % 5 == 0);
            default:   i_out_ready <= ($urandom_range(0, 11) == 0);
        endcase
    end

    function automatic logic [rtv_pkg::ROW_W-1:0] pack_row(int c0, int c1, int c2);
        return {16'(c2), 16'(c1), 16'(c0)};
    endfunction

    function automatic rtv_pkg::t_cfg make_setting(
        input logic [rtv_pkg::ROW_W-1:0]    r0,
        input logic [rtv_pkg::ROW_W-1:0]    r1,
        input logic [rtv_pkg::ROW_W-1:0]    r2,
        input logic [rtv_pkg::OFFSET_W-1:0] f,
        input logic [rtv_pkg::OFFSET_W-1:0] g,
        input logic [rtv_pkg::OFFSET_W-1:0] d,
        input logic [rtv_pkg::TOL_W-1:0]    tol
    );
        rtv_pkg::t_cfg s;
        s.rot[0]  = r0;
        s.rot[1]  = r1;
        s.rot[2]  = r2;
        s.offs[0] = f;
        s.offs[1] = g;
        s.offs[2] = d;
        s.tol     = tol;
        return s;
    endfunction

    function automatic t_cam_point point(
        input logic signed [CW-1:0] x,
        input logic signed [CW-1:0] y,
        input logic signed [CW-1:0] z
    );
        t_cam_point p;
        p.right   = x;
        p.down    = y;
        p.forward = z;
        return p;
    endfunction

    function automatic logic signed [CW-1:0] random_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom;
            5, 6, 7:       return int'($urandom_range(0, 1 << 19)) - (1 << 18);
            8:             return ($urandom_range(0, 1) == 1) ? CAM_MAX : CAM_MIN;
            default:       return int'($urandom_range(0, 2)) - 1;
        endcase
    endfunction

    // Mostly proper rotations: signed permutations with determinant one, often
    // with small noise on every entry. The rest are arbitrary matrices.
    function automatic rtv_pkg::t_cfg random_setting();
        rtv_pkg::t_cfg s;
        int   perm[3];
        int   sgn[3];
        int   ent[3][3];
        int   flips;
        int   j;
        int   tmp;
        if ($urandom_range(0, 9) >= 8) begin
            for (int r = 0; r < 3; r++) s.rot[r] = {16'($urandom), $urandom};
        end else begin
            perm = '{0, 1, 2};
            for (int k = 2; k > 0; k--) begin
                j       = $urandom_range(0, k);
                tmp     = perm[k];
                perm[k] = perm[j];
                perm[j] = tmp;
            end
            flips = int'(perm[0] > perm[1]) + int'(perm[0] > perm[2]) + int'(perm[1] > perm[2]);
            for (int r = 0; r < 3; r++) begin
                sgn[r] = ($urandom_range(0, 1) == 1) ? -1 : 1;
                if (sgn[r] < 0) flips++;
            end
            if (flips % 2 == 1) sgn[2] = -sgn[2];
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    ent[r][c] = (c == perm[r]) ? sgn[r] * UNIT : 0;
            if ($urandom_range(0, 1) == 1)
                foreach (ent[r, c]) ent[r][c] += int'($urandom_range(0, 8)) - 4;
            for (int r = 0; r < 3; r++) s.rot[r] = pack_row(ent[r][0], ent[r][1], ent[r][2]);
        end
        for (int r = 0; r < 3; r++)
            case ($urandom_range(0, 3))
                0:       s.offs[r] = $urandom;
                1:       s.offs[r] = int'($urandom_range(0, 1 << 22)) - (1 << 21);
                2:       s.offs[r] = ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                default: s.offs[r] = '0;
            endcase
        case ($urandom_range(0, 4))
            0:       s.tol = '0;
            1:       s.tol = rtv_pkg::RST_ORTHO_TOLERANCE;
            2:       s.tol = rtv_pkg::TOL_W'($urandom_range(0, 1 << 20));
            3:       s.tol = '1;
            default: s.tol = rtv_pkg::TOL_W'($urandom);
        endcase
        return s;
    endfunction

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_point(input t_cam_point p);
        pace_sender();
        i_in_valid    <= 1'b1;
        i_cam_right   <= p.right;
        i_cam_down    <= p.down;
        i_cam_forward <= p.forward;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_camera_point(p);
    endtask

    // Registers only change once every point in flight has come out.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_body_points.size() != 0);
    endtask

    task automatic write_reg(input logic [rtv_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [rtv_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Unused upper data bits carry noise that the block must drop.
    task automatic load_setting(input rtv_pkg::t_cfg s);
        write_reg(rtv_pkg::REG_ROT_ROW_ZERO, s.rot[0]);
        write_reg(rtv_pkg::REG_ROT_ROW_ONE, s.rot[1]);
        write_reg(rtv_pkg::REG_ROT_ROW_TWO, s.rot[2]);
        write_reg(rtv_pkg::REG_OFFSET_FWD, {16'($urandom), s.offs[0]});
        write_reg(rtv_pkg::REG_OFFSET_RGT, {16'($urandom), s.offs[1]});
        write_reg(rtv_pkg::REG_OFFSET_DWN, {16'($urandom), s.offs[2]});
        write_reg(rtv_pkg::REG_ORTHO_TOLERANCE, {19'($urandom), s.tol});
        i_cfg_we <= 1'b0;
        setting_count++;
    endtask

    initial begin
        int n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: identity, no offset.
        send_point(point(0, 0, 0));
        send_point(point(CAM_MAX, CAM_MAX, CAM_MAX));
        send_point(point(CAM_MIN, CAM_MIN, CAM_MIN));
        send_point(point(1, -1, 32'h1234_5678));

        // Camera axes to body axes with extreme offsets and zero tolerance,
        // so the sums clip at both ends.
        drain();
        load_setting(make_setting(pack_row(0, 0, UNIT), pack_row(UNIT, 0, 0),
                                  pack_row(0, UNIT, 0), 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h0001_0000, '0));
        send_point(point(CAM_MAX, CAM_MAX, CAM_MAX));
        send_point(point(CAM_MIN, CAM_MIN, CAM_MIN));
        send_point(point(0, 0, 0));

        // Yaw of 45 degrees: inexact entries, and halfway cases in rounding.
        drain();
        load_setting(make_setting(pack_row(C45, -C45, 0), pack_row(C45, C45, 0),
                                  pack_row(0, 0, UNIT), '0, '0, '0,
                                  rtv_pkg::RST_ORTHO_TOLERANCE));
        send_point(point(8192, 0, 5));
        send_point(point(-8192, 0, -5));
        send_point(point(3, 7, 100));
        send_point(point(CAM_MAX, CAM_MIN, 0));

        // The same yaw is no longer unit length once the tolerance is zero.
        drain();
        load_setting(make_setting(pack_row(C45, -C45, 0), pack_row(C45, C45, 0),
                                  pack_row(0, 0, UNIT), '0, '0, '0, '0));
        send_point(point(100, 200, 300));

        // Most negative entries fail even with the widest tolerance.
        drain();
        load_setting(make_setting(pack_row(-32768, -32768, -32768),
                                  pack_row(-32768, -32768, -32768),
                                  pack_row(-32768, -32768, -32768), '0, '0, '0, '1));
        send_point(point(5, 5, 5));

        // Two equal rows.
        drain();
        load_setting(make_setting(pack_row(UNIT, 0, 0), pack_row(UNIT, 0, 0),
                                  pack_row(0, 0, UNIT), '0, '0, '0,
                                  rtv_pkg::RST_ORTHO_TOLERANCE));
        send_point(point(5, 5, 5));

        // Mirror image: left-handed frame.
        drain();
        load_setting(make_setting(pack_row(UNIT, 0, 0), pack_row(0, UNIT, 0),
                                  pack_row(0, 0, -UNIT), '0, '0, '0,
                                  rtv_pkg::RST_ORTHO_TOLERANCE));
        send_point(point(5, 5, 5));

        // A write to an unmapped index must leave the mirror in place.
        drain();
        write_reg(REG_UNMAPPED, pack_row(0, 0, UNIT));
        i_cfg_we <= 1'b0;
        send_point(point(-7, 9, 11));

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            load_setting(random_setting());
            n = $urandom_range(55, 80);
            repeat (n) send_point(point(random_coord(), random_coord(), random_coord()));
        end

        drain();
        repeat (12) @(posedge i_clk);
        $display("Checked %0d body points over %0d register settings, %0d of them clipped.",
                 sb.checked, setting_count, sb.saturated_count);
        $display("Status mix: %0d ok, %0d not unit, %0d not orthogonal, %0d left-handed.",
                 sb.status_count[rtv_pkg::ST_OK], sb.status_count[rtv_pkg::ST_NOT_UNIT],
                 sb.status_count[rtv_pkg::ST_NOT_ORTHO], sb.status_count[rtv_pkg::ST_NOT_RIGHT]);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
